/* design/wmd_pkg.sv */
// Shared constants, types and the level scaling function for the
// waveform min/max decimator. No dependencies.
package wmd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int CHANNELS    = 8;
  localparam int CH_BITS     = 3;
  localparam int LEVEL_BITS  = 8;
  localparam int COUNT_BITS  = 16;
  localparam int PROD_BITS   = SAMPLE_BITS + LEVEL_BITS;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [CFG_ADDR_BITS-1:0] REG_SAMPLES_PER_BIN = 3'd0;

  localparam logic [COUNT_BITS-1:0] SPB_RESET = 16'd512;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic signed [LEVEL_BITS-1:0] LEVEL_MAX = 8'sd127;
  localparam logic signed [LEVEL_BITS-1:0] LEVEL_MIN = -8'sd128;

  typedef struct packed {
    logic [CH_BITS-1:0]            channel;
    logic signed [SAMPLE_BITS-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] hi;
    logic                          short_bin;
  } bin_t;

  // scale by 127 / 2^(SAMPLE_BITS-1), round half away from zero, saturate
  function automatic logic signed [LEVEL_BITS-1:0] scale_level(
    input logic signed [SAMPLE_BITS-1:0] s
  );
    logic signed [PROD_BITS-1:0] ext;
    logic signed [PROD_BITS-1:0] prod;
    logic                        neg;
    logic [PROD_BITS-1:0]        mag;
    logic [PROD_BITS-1:0]        q;
    logic signed [LEVEL_BITS-1:0] r;
    ext  = PROD_BITS'(s);
    prod = (ext <<< 7) - ext;
    neg  = prod[PROD_BITS-1];
    mag  = neg ? PROD_BITS'(-prod) : PROD_BITS'(prod);
    q    = (mag + (PROD_BITS'(1) << (SAMPLE_BITS-2))) >> (SAMPLE_BITS-1);
    if (!neg) begin
      r = (q > PROD_BITS'(127)) ? LEVEL_MAX : LEVEL_BITS'(q);
    end else begin
      r = (q > PROD_BITS'(128)) ? LEVEL_MIN : LEVEL_BITS'(-q);
    end
    return r;
  endfunction

endpackage

/* design/wmd_bins.sv */
// Input register and per-channel min/max/count bins; emits a closed bin.
// Depends on wmd_pkg.
module wmd_bins (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [wmd_pkg::COUNT_BITS-1:0]  samples_per_bin,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wmd_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic [wmd_pkg::CH_BITS-1:0]     in_channel,
  input  logic                            in_end,
  output logic                            bin_valid,
  input  logic                            bin_ready,
  output wmd_pkg::bin_t                   bin_out
);
  import wmd_pkg::*;

  logic                          s1_v_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic [CH_BITS-1:0]            s1_ch_r;
  logic                          s1_end_r;

  logic signed [SAMPLE_BITS-1:0] min_r [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] max_r [CHANNELS];
  logic [COUNT_BITS-1:0]         cnt_r [CHANNELS];

  logic  b_v_r;
  bin_t  b_r;

  logic                          adv_b;
  logic                          consume;
  logic signed [SAMPLE_BITS-1:0] min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_nxt;
  logic [COUNT_BITS-1:0]         cnt_nxt;
  logic [COUNT_BITS-1:0]         spb_eff;
  logic                          full;
  logic                          close;

  assign adv_b    = !b_v_r || bin_ready;
  assign consume  = s1_v_r && adv_b;
  assign in_ready = !s1_v_r || adv_b;

  always_comb begin
    min_nxt = (s1_sample_r < min_r[s1_ch_r]) ? s1_sample_r : min_r[s1_ch_r];
    max_nxt = (s1_sample_r > max_r[s1_ch_r]) ? s1_sample_r : max_r[s1_ch_r];
    cnt_nxt = (cnt_r[s1_ch_r] == COUNT_MAX) ? cnt_r[s1_ch_r]
                                            : cnt_r[s1_ch_r] + COUNT_BITS'(1);
    spb_eff = (samples_per_bin == '0) ? COUNT_BITS'(1) : samples_per_bin;
    full    = (cnt_nxt >= spb_eff);
    close   = full || s1_end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
    if (in_ready) begin
      s1_sample_r <= in_sample;
      s1_ch_r     <= in_channel;
      s1_end_r    <= in_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        min_r[i] <= SAMPLE_TOP;
        max_r[i] <= SAMPLE_BOTTOM;
        cnt_r[i] <= '0;
      end
    end else if (consume) begin
      if (close) begin
        min_r[s1_ch_r] <= SAMPLE_TOP;
        max_r[s1_ch_r] <= SAMPLE_BOTTOM;
        cnt_r[s1_ch_r] <= '0;
      end else begin
        min_r[s1_ch_r] <= min_nxt;
        max_r[s1_ch_r] <= max_nxt;
        cnt_r[s1_ch_r] <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv_b) begin
      b_v_r <= consume && close;
    end
    if (adv_b) begin
      b_r.channel   <= s1_ch_r;
      b_r.lo        <= min_nxt;
      b_r.hi        <= max_nxt;
      b_r.short_bin <= !full;
    end
  end

  assign bin_valid = b_v_r;
  assign bin_out   = b_r;

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && close) |=> (cnt_r[$past(s1_ch_r)] == '0))
    else $error("closed bin did not clear its count");

  a_empty_bin_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[s1_ch_r] == '0) |->
      (min_r[s1_ch_r] == SAMPLE_TOP && max_r[s1_ch_r] == SAMPLE_BOTTOM))
    else $error("empty bin holds stale extremes");

  a_bin_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r |-> (b_r.lo <= b_r.hi))
    else $error("closed bin has minimum above maximum");

endmodule

/* design/wmd_scale.sv */
// Level scaling, equal-level separation and output register.
// Depends on wmd_pkg.
module wmd_scale (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                bin_valid,
  output logic                                bin_ready,
  input  wmd_pkg::bin_t                       bin_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wmd_pkg::CH_BITS-1:0]         out_channel,
  output logic signed [wmd_pkg::LEVEL_BITS-1:0] out_min,
  output logic signed [wmd_pkg::LEVEL_BITS-1:0] out_max,
  output logic                                out_short
);
  import wmd_pkg::*;

  logic                         vo_r;
  logic [CH_BITS-1:0]           ch_r;
  logic signed [LEVEL_BITS-1:0] min_r;
  logic signed [LEVEL_BITS-1:0] max_r;
  logic                         short_r;

  logic                         adv;
  logic signed [LEVEL_BITS-1:0] lo;
  logic signed [LEVEL_BITS-1:0] hi;
  logic signed [LEVEL_BITS-1:0] lo_nxt;
  logic signed [LEVEL_BITS-1:0] hi_nxt;

  assign adv       = !vo_r || out_ready;
  assign bin_ready = adv;

  always_comb begin
    lo     = scale_level(bin_in.lo);
    hi     = scale_level(bin_in.hi);
    lo_nxt = lo;
    hi_nxt = hi;
    if (lo == hi) begin
      if (hi == LEVEL_MAX) begin
        lo_nxt = lo - LEVEL_BITS'(1);
      end else begin
        hi_nxt = hi + LEVEL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (adv) begin
      vo_r <= bin_valid;
    end
    if (adv) begin
      ch_r    <= bin_in.channel;
      min_r   <= lo_nxt;
      max_r   <= hi_nxt;
      short_r <= bin_in.short_bin;
    end
  end

  assign out_valid   = vo_r;
  assign out_channel = ch_r;
  assign out_min     = min_r;
  assign out_max     = max_r;
  assign out_short   = short_r;

  a_levels_apart: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> (min_r < max_r))
    else $error("output levels not separated");

endmodule

/* design/waveform_minmax_decimator.sv */
// Top level of the waveform min/max decimator: config register and the
// bin and scale stages. Depends on wmd_pkg, wmd_bins, wmd_scale.
//
// channel  | direction | contents
// in_      | slave     | tdata sample, tuser channel, tlast block end
// out_     | master    | tdata min/max levels, tuser channel and short-bin flag
// cfg_     | APB slave | samples_per_bin at byte address 0
//
// One item per cycle sustained while out_ does not stall; a closed bin reaches out_
// through the input register, bin register and output register after its closing item is accepted.
// Reset is synchronous, active low, clears every bin and sets samples_per_bin to 512.
// A stall on out_ backs up through the three registers before in_tready drops.
module waveform_minmax_decimator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,  // [15:0] sample
  input  logic [2:0]                        in_tuser,  // [2:0] channel
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata, // [7:0] min_level, [15:8] max_level
  output logic [3:0]                        out_tuser, // [2:0] out_channel, [3] short_bin
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wmd_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import wmd_pkg::*;

  logic [COUNT_BITS-1:0]         spb_r;
  logic                          bin_valid;
  logic                          bin_ready;
  bin_t                          bin;
  logic [CH_BITS-1:0]            out_channel;
  logic signed [LEVEL_BITS-1:0]  out_min;
  logic signed [LEVEL_BITS-1:0]  out_max;
  logic                          out_short;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r <= SPB_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_SAMPLES_PER_BIN) begin
      spb_r <= cfg_pwdata[COUNT_BITS-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == REG_SAMPLES_PER_BIN) ? {16'd0, spb_r} : 32'd0;

  wmd_bins u_bins (
    .clk             (clk),
    .rst_n           (rst_n),
    .samples_per_bin (spb_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_sample       (in_tdata),
    .in_channel      (in_tuser),
    .in_end          (in_tlast),
    .bin_valid       (bin_valid),
    .bin_ready       (bin_ready),
    .bin_out         (bin)
  );

  wmd_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .bin_valid   (bin_valid),
    .bin_ready   (bin_ready),
    .bin_in      (bin),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_channel (out_channel),
    .out_min     (out_min),
    .out_max     (out_max),
    .out_short   (out_short)
  );

  assign out_tdata = {out_max, out_min};
  assign out_tuser = {out_short, out_channel};

endmodule
